FILE: src/sfl_pkg.sv
package sfl_pkg;

    // Default sizing of the pool and of the size classes
    localparam int POOL_BYTES_DEF      = 65536;
    localparam int MAX_CLASS_BYTES_DEF = 1024;
    localparam int GRAIN_BYTES_DEF     = 4;

    // Width of a byte size once rounded up to the grain
    localparam int SIZE_SUM_W = 17;

    // Result status codes
    localparam logic [2:0] ST_FROM_LIST = 3'd0;
    localparam logic [2:0] ST_FROM_POOL = 3'd1;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
    localparam logic [2:0] ST_EXHAUSTED = 3'd3;
    localparam logic [2:0] ST_FREED     = 3'd4;
    localparam logic [2:0] ST_IGNORED   = 3'd5;

    // Request operations
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] size_bytes;
        logic [15:0] block_address;
    } req_t;

    typedef struct packed {
        logic [15:0] result_address;
        logic [2:0]  status;
        logic [16:0] pool_bytes_used;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic link_rd;
        logic commit_head;
        logic commit_link;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pop_path;
        logic out_free;
    } stat_t;

endpackage

FILE: src/size_class_free_list_allocator_top.sv
// A request is taken when idle; its result is registered in the head-read state, or in
// the link-read state when an allocation pops a free list; the pop reads the head RAM
// and then the link RAM before the head is rewritten. The next request waits for idle.
// Reset clears the controller, the pool pointer, the output valid and the list-valid
// flops, so every list starts empty; head and link RAMs need no clearing pass.
module size_class_free_list_allocator_top #(
    parameter int POOL_BYTES      = sfl_pkg::POOL_BYTES_DEF,
    parameter int MAX_CLASS_BYTES = sfl_pkg::MAX_CLASS_BYTES_DEF,
    parameter int GRAIN_BYTES     = sfl_pkg::GRAIN_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sfl_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sfl_pkg::rsp_t rsp
);

    // Command and status between the sequencer and the datapath.
    // The sequencer takes a request transfer only when idle; the result
    // register lets a finished result wait while the next request is taken.
    sfl_pkg::cmd_t  cmd;
    sfl_pkg::stat_t stat;

    // Sequencer: idle, head read, link read (list pop only)
    sfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: request decode, head and link RAMs, list-valid flops,
    // pool pointer and the result register
    sfl_datapath #(
        .POOL_BYTES     (POOL_BYTES),
        .MAX_CLASS_BYTES(MAX_CLASS_BYTES),
        .GRAIN_BYTES    (GRAIN_BYTES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .stat     (stat),
        .rsp_stall(rsp_stall),
        .rsp_valid(rsp_valid),
        .rsp      (rsp)
    );

endmodule

FILE: src/sfl_ram.sv
module sfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        // hold read data until the next read
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/sfl_ctrl.sv
module sfl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sfl_pkg::stat_t stat,
    output sfl_pkg::cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HEAD = 2'd1;
    localparam logic [1:0] S_LINK = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                // head word is on the RAM output now
                if (stat.pop_path)
                begin
                    cmd.link_rd = 1'b1;
                    state_next  = S_LINK;
                end
                else if (stat.out_free)
                begin
                    cmd.commit_head = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_LINK:
            begin
                if (stat.out_free)
                begin
                    cmd.commit_link = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

FILE: src/sfl_datapath.sv
module sfl_datapath #(
    parameter int POOL_BYTES      = sfl_pkg::POOL_BYTES_DEF,
    parameter int MAX_CLASS_BYTES = sfl_pkg::MAX_CLASS_BYTES_DEF,
    parameter int GRAIN_BYTES     = sfl_pkg::GRAIN_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  sfl_pkg::req_t  req,
    input  sfl_pkg::cmd_t  cmd,
    output sfl_pkg::stat_t stat,
    input  logic           rsp_stall,
    output logic           rsp_valid,
    output sfl_pkg::rsp_t  rsp
);

    localparam int GL          = $clog2(GRAIN_BYTES);
    localparam int CLASS_COUNT = MAX_CLASS_BYTES / GRAIN_BYTES + 1;
    localparam int CLASS_W     = $clog2(CLASS_COUNT);
    localparam int WORD_COUNT  = POOL_BYTES / GRAIN_BYTES;
    localparam int WORD_W      = $clog2(WORD_COUNT);
    localparam int BUMP_W      = $clog2(POOL_BYTES + 1);
    localparam int SW          = sfl_pkg::SIZE_SUM_W;

    // incoming request decode
    logic [SW-1:0]   sum_in;
    logic [SW-1:0]   cls_in;
    logic [SW-1:0]   rounded_in;
    logic            small_in;
    logic [31:0]     word_in;

    assign sum_in     = SW'(req.size_bytes) + SW'(GRAIN_BYTES - 1);
    assign cls_in     = sum_in >> GL;
    assign rounded_in = cls_in << GL;
    assign small_in   = (32'(rounded_in) <= 32'(MAX_CLASS_BYTES));
    assign word_in    = 32'(req.block_address) >> GL;

    // latched request
    logic               func_reg;
    logic               zero_reg;
    logic               small_reg;
    logic [SW-1:0]      rounded_reg;
    logic [CLASS_W-1:0] cls_reg;
    logic [WORD_W-1:0]  word_reg;
    logic               word_ok_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg    <= req.func;
            zero_reg    <= (req.size_bytes == '0);
            small_reg   <= small_in;
            rounded_reg <= rounded_in;
            cls_reg     <= cls_in[CLASS_W-1:0];
            word_reg    <= word_in[WORD_W-1:0];
            word_ok_reg <= (word_in < 32'(WORD_COUNT));
        end
    end

    // list storage
    logic [CLASS_COUNT-1:0] head_valid_reg;
    logic [CLASS_COUNT-1:0] head_valid_next;
    logic                   head_valid_cur;
    logic                   head_wr_en;
    logic [WORD_W-1:0]      head_wr_data;
    logic [WORD_W-1:0]      head_rd_data;
    logic                   link_wr_en;
    logic [WORD_W:0]        link_rd_data;

    assign head_valid_cur = small_reg && head_valid_reg[cls_reg];

    sfl_ram #(
        .WIDTH(WORD_W),
        .DEPTH(CLASS_COUNT)
    ) u_head_ram (
        .clk    (clk),
        .wr_en  (head_wr_en),
        .wr_addr(cls_reg),
        .wr_data(head_wr_data),
        .rd_en  (cmd.accept),
        .rd_addr(cls_in[CLASS_W-1:0]),
        .rd_data(head_rd_data)
    );

    sfl_ram #(
        .WIDTH(WORD_W + 1),
        .DEPTH(WORD_COUNT)
    ) u_link_ram (
        .clk    (clk),
        .wr_en  (link_wr_en),
        .wr_addr(word_reg),
        .wr_data({head_valid_cur, head_rd_data}),
        .rd_en  (cmd.link_rd),
        .rd_addr(head_rd_data),
        .rd_data(link_rd_data)
    );

    // pool pointer; it also equals the running pool total
    logic [BUMP_W-1:0] bump_reg;
    logic [BUMP_W-1:0] bump_next;
    logic              exhausted;
    logic              free_ok;

    assign exhausted = (32'(rounded_reg) + 32'(bump_reg)) > 32'(POOL_BYTES);
    assign free_ok   = small_reg && word_ok_reg && !zero_reg;

    assign stat.pop_path = (func_reg == sfl_pkg::FUNC_ALLOC) && !zero_reg && head_valid_cur;
    assign stat.out_free = !rsp_valid || !rsp_stall;

    // result register
    logic          out_valid_reg;
    logic          out_valid_next;
    sfl_pkg::rsp_t out_data_reg;
    sfl_pkg::rsp_t out_data_next;

    always_comb
    begin
        head_wr_en      = 1'b0;
        head_wr_data    = word_reg;
        link_wr_en      = 1'b0;
        head_valid_next = head_valid_reg;
        bump_next       = bump_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && rsp_stall;

        if (cmd.commit_link)
        begin
            // advance the list head to the popped block's link
            head_wr_en               = 1'b1;
            head_wr_data             = link_rd_data[WORD_W-1:0];
            head_valid_next[cls_reg] = link_rd_data[WORD_W];
            out_data_next.result_address = 16'(32'(head_rd_data) << GL);
            out_data_next.status         = sfl_pkg::ST_FROM_LIST;
            out_valid_next               = 1'b1;
        end
        else if (cmd.commit_head)
        begin
            out_data_next.result_address = '0;
            out_valid_next               = 1'b1;
            if (zero_reg)
            begin
                out_data_next.status = (func_reg == sfl_pkg::FUNC_FREE) ?
                                       sfl_pkg::ST_IGNORED : sfl_pkg::ST_ZERO_SIZE;
            end
            else if (func_reg == sfl_pkg::FUNC_ALLOC)
            begin
                if (exhausted)
                begin
                    out_data_next.status = sfl_pkg::ST_EXHAUSTED;
                end
                else
                begin
                    bump_next = bump_reg + BUMP_W'(rounded_reg);
                    out_data_next.result_address = 16'(bump_reg);
                    out_data_next.status         = sfl_pkg::ST_FROM_POOL;
                end
            end
            else if (free_ok)
            begin
                // push the block: link to old head, block becomes the head
                link_wr_en               = 1'b1;
                head_wr_en               = 1'b1;
                head_valid_next[cls_reg] = 1'b1;
                out_data_next.status     = sfl_pkg::ST_FREED;
            end
            else
            begin
                out_data_next.status = sfl_pkg::ST_IGNORED;
            end
        end
        out_data_next.pool_bytes_used = 17'(bump_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= '0;
            bump_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            bump_reg       <= bump_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

endmodule
